// ===== hdl/stt_pkg.sv =====
package stt_pkg;

	localparam int PosW        = 16;
	localparam int OutW        = 16;
	localparam int QueueDepth  = 4;
	localparam int QPtrW       = $clog2(QueueDepth);
	localparam int QCntW       = QPtrW + 1;
	localparam int MaxPerByte  = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	typedef enum logic [2:0] {
		CLS_PUNCT = 3'd0,
		CLS_INT   = 3'd1,
		CLS_FLOAT = 3'd2,
		CLS_NAME  = 3'd3,
		CLS_OPER  = 3'd4,
		CLS_ERROR = 3'd5,
		CLS_END   = 3'd6
	} tok_class_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		tok_class_t      token_class;
		logic [OutW-1:0] token_start;
		logic [OutW-1:0] token_length;
		logic            last_of_run;
	} tok_item_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [1:0]                       count;
		tok_item_t [MaxPerByte-1:0]       item;
	} tok_group_t;

	function automatic logic [PosW-1:0] sat_inc(logic [PosW-1:0] v);
		return (v == '1) ? v : v + PosW'(1);
	endfunction

	function automatic logic [OutW-1:0] sat_out(logic [PosW-1:0] v);
		logic [PosW+OutW-1:0] wide;
		wide = (PosW+OutW)'(v);
		if ((wide >> OutW) != '0)
			return '1;
		return wide[OutW-1:0];
	endfunction

	function automatic tok_item_t make_tok(tok_class_t cls, logic [PosW-1:0] start,
			logic [PosW-1:0] len);
		tok_item_t t;
		t.token_class  = cls;
		t.token_start  = sat_out(start);
		t.token_length = sat_out(len);
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		case (b) inside
			8'h20, 8'h0A, 8'h09, 8'h0D: return 1'b1;
			default:                    return 1'b0;
		endcase
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_name(logic [7:0] b);
		return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
			((b >= 8'h41) && (b <= 8'h5A)) || (b == 8'h5F);
	endfunction

	// ( ) { } [ ] ; ,
	function automatic logic is_punct(logic [7:0] b);
		case (b) inside
			8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// = + - * / ! % & ~ | < > ? : . #
	function automatic logic is_oper(logic [7:0] b);
		case (b) inside
			8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h21, 8'h25, 8'h26,
			8'h7E, 8'h7C, 8'h3C, 8'h3E, 8'h3F, 8'h3A, 8'h2E, 8'h23: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

endpackage

// ===== hdl/stt_front.sv =====
module stt_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  stt_pkg::src_item_t     src_data,
	output logic                   push_valid,
	input  logic                   push_ready,
	output stt_pkg::tok_group_t    push_data
);

	typedef enum logic [9:0] {
		SCAN_IDLE    = 10'b00_0000_0001,
		SCAN_INT     = 10'b00_0000_0010,
		SCAN_FLOAT   = 10'b00_0000_0100,
		SCAN_NAME    = 10'b00_0000_1000,
		SCAN_OPER    = 10'b00_0001_0000,
		SCAN_SLASH   = 10'b00_0010_0000,
		SCAN_COMMENT = 10'b00_0100_0000,
		SCAN_CSTAR   = 10'b00_1000_0000,
		SCAN_ERRSKIP = 10'b01_0000_0000,
		SCAN_DONE    = 10'b10_0000_0000
	} scan_mode_t;

	scan_mode_t                  mode_q, mode_d;
	logic [stt_pkg::PosW-1:0]    pstart_q, pstart_d;
	logic [stt_pkg::PosW-1:0]    plen_q, plen_d;
	logic [stt_pkg::PosW-1:0]    pos_q, pos_d;
	logic                        accept;

	logic [3:0]                  cand_v;
	stt_pkg::tok_item_t [3:0]    cand;
	stt_pkg::tok_group_t         group;
	logic [1:0]                  n;
	logic                        ends, cont, start;
	logic [7:0]                  b;

	function automatic logic pend_valid(scan_mode_t m);
		case (m) inside
			SCAN_INT, SCAN_FLOAT, SCAN_NAME, SCAN_OPER, SCAN_SLASH: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic stt_pkg::tok_class_t pend_class(scan_mode_t m);
		case (m)
			SCAN_INT:   return stt_pkg::CLS_INT;
			SCAN_FLOAT: return stt_pkg::CLS_FLOAT;
			SCAN_NAME:  return stt_pkg::CLS_NAME;
			default:    return stt_pkg::CLS_OPER;
		endcase
	endfunction

	always_comb begin
		mode_d   = mode_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		pos_d    = pos_q;
		cand_v   = '0;
		cand     = '0;
		group    = '0;
		n        = '0;
		ends     = 1'b0;
		cont     = 1'b0;
		start    = 1'b0;
		b        = src_data.text_byte;

		if (mode_q == SCAN_ERRSKIP || mode_q == SCAN_DONE) begin
			// drop bytes until the end flag
		end else if (b == stt_pkg::CH_NUL) begin
			if (mode_d == SCAN_COMMENT || mode_d == SCAN_CSTAR) begin
				cand_v[0] = 1'b1;
				cand[0]   = stt_pkg::make_tok(stt_pkg::CLS_ERROR, pstart_d, '0);
			end else if (pend_valid(mode_d)) begin
				cand_v[0] = 1'b1;
				cand[0]   = stt_pkg::make_tok(pend_class(mode_d), pstart_d, plen_d);
			end
			cand_v[3] = 1'b1;
			cand[3]   = stt_pkg::make_tok(stt_pkg::CLS_END, pos_q, '0);
			mode_d    = SCAN_DONE;
		end else begin
			unique case (mode_q)
				SCAN_COMMENT: begin
					if (b == stt_pkg::CH_STAR)
						mode_d = SCAN_CSTAR;
				end
				SCAN_CSTAR: begin
					if (b == stt_pkg::CH_SLASH)
						mode_d = SCAN_IDLE;
					else if (b != stt_pkg::CH_STAR)
						mode_d = SCAN_COMMENT;
				end
				SCAN_SLASH: begin
					if (b == stt_pkg::CH_STAR) begin
						mode_d = SCAN_COMMENT;
					end else begin
						mode_d = SCAN_OPER;
						ends   = !stt_pkg::is_oper(b);
						cont   = 1'b1;
					end
				end
				SCAN_INT: begin
					if (b == stt_pkg::CH_DOT)
						mode_d = SCAN_FLOAT;
					else
						ends = !stt_pkg::is_digit(b);
					cont = 1'b1;
				end
				SCAN_FLOAT: begin
					ends = !stt_pkg::is_digit(b);
					cont = 1'b1;
				end
				SCAN_NAME: begin
					ends = !stt_pkg::is_name(b);
					cont = 1'b1;
				end
				SCAN_OPER: begin
					ends = !stt_pkg::is_oper(b);
					cont = 1'b1;
				end
				SCAN_IDLE: start = 1'b1;
				default: ;
			endcase

			if (cont) begin
				if (ends) begin
					cand_v[0] = 1'b1;
					cand[0]   = stt_pkg::make_tok(pend_class(mode_d), pstart_d, plen_d);
					mode_d    = SCAN_IDLE;
					start     = 1'b1;
				end else begin
					plen_d = stt_pkg::sat_inc(plen_d);
				end
			end

			if (start) begin
				if (stt_pkg::is_space(b)) begin
					// skip
				end else if (b == stt_pkg::CH_SLASH) begin
					mode_d   = SCAN_SLASH;
					pstart_d = pos_q;
					plen_d   = stt_pkg::PosW'(1);
				end else if (stt_pkg::is_punct(b)) begin
					cand_v[1] = 1'b1;
					cand[1]   = stt_pkg::make_tok(stt_pkg::CLS_PUNCT, pos_q,
						stt_pkg::PosW'(1));
				end else if (stt_pkg::is_digit(b)) begin
					mode_d   = SCAN_INT;
					pstart_d = pos_q;
					plen_d   = stt_pkg::PosW'(1);
				end else if (stt_pkg::is_name(b)) begin
					mode_d   = SCAN_NAME;
					pstart_d = pos_q;
					plen_d   = stt_pkg::PosW'(1);
				end else if (stt_pkg::is_oper(b)) begin
					mode_d   = SCAN_OPER;
					pstart_d = pos_q;
					plen_d   = stt_pkg::PosW'(1);
				end else begin
					cand_v[1] = 1'b1;
					cand[1]   = stt_pkg::make_tok(stt_pkg::CLS_ERROR, pos_q, '0);
					mode_d    = SCAN_ERRSKIP;
				end
			end
		end

		if (src_data.end_of_text) begin
			if (mode_d == SCAN_COMMENT || mode_d == SCAN_CSTAR) begin
				cand_v[2] = 1'b1;
				cand[2]   = stt_pkg::make_tok(stt_pkg::CLS_ERROR, pstart_d, '0);
			end else if (pend_valid(mode_d)) begin
				cand_v[2] = 1'b1;
				cand[2]   = stt_pkg::make_tok(pend_class(mode_d), pstart_d, plen_d);
			end
			if (mode_d != SCAN_DONE) begin
				cand_v[3] = 1'b1;
				cand[3]   = stt_pkg::make_tok(stt_pkg::CLS_END, stt_pkg::sat_inc(pos_q), '0);
			end
			mode_d   = SCAN_IDLE;
			pstart_d = '0;
			plen_d   = '0;
			pos_d    = '0;
		end else begin
			pos_d = stt_pkg::sat_inc(pos_q);
		end

		// pack the candidates in order; at most three are ever set
		for (int k = 0; k < 4; k++) begin
			if (cand_v[k]) begin
				group.item[n] = cand[k];
				n = n + 2'd1;
			end
		end
		for (int j = 0; j < stt_pkg::MaxPerByte; j++)
			group.item[j].last_of_run = (2'(j) == n - 2'd1);
		group.count = n;
	end

	assign src_ready  = push_ready;
	assign accept     = src_valid && src_ready;
	assign push_valid = accept && (n != 2'd0);
	assign push_data  = group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= SCAN_IDLE;
			pstart_q <= '0;
			plen_q   <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			pos_q    <= pos_d;
		end
	end

endmodule

// ===== hdl/stt_queue.sv =====
module stt_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  stt_pkg::tok_group_t    push_data,
	output logic                   head_valid,
	input  logic                   pop,
	output stt_pkg::tok_group_t    head
);

	stt_pkg::tok_group_t          slot_q [stt_pkg::QueueDepth];
	logic [stt_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [stt_pkg::QCntW-1:0]    cnt_q;
	logic                         do_push, do_pop;

	assign push_ready = (cnt_q != stt_pkg::QCntW'(stt_pkg::QueueDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + stt_pkg::QPtrW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + stt_pkg::QPtrW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + stt_pkg::QCntW'(1);
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - stt_pkg::QCntW'(1);
		end
	end

endmodule

// ===== hdl/stt_back.sv =====
module stt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  stt_pkg::tok_group_t    head,
	output logic                   pop,
	output logic                   tok_valid,
	input  logic                   tok_ready,
	output stt_pkg::tok_item_t     tok_data
);

	logic                  out_valid_q;
	stt_pkg::tok_item_t    out_q;
	logic [1:0]            sub_q;
	logic                  load;

	// refill the output register whenever it is empty or being taken
	assign load = head_valid && (!out_valid_q || tok_ready);
	assign pop  = load && (sub_q == head.count - 2'd1);

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.item[sub_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (tok_ready)
				out_valid_q <= 1'b0;
			if (pop)
				sub_q <= '0;
			else if (load)
				sub_q <= sub_q + 2'd1;
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_data  = out_q;

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Source text tokenizer: takes one text byte per cycle on src and reports tokens on tok
// (class, start offset, length, and a flag on the last token a byte caused). The scanner
// accepts a byte every cycle as long as its four-entry queue of per-byte result groups has
// room; a byte that ends a token, closes the text or hits an error may cause up to three
// results, and the output side delivers one result per cycle while tok_ready is high, so
// such bytes take one output slot per result. A result reaches tok through the queue and
// the output register. Offsets and lengths saturate at 65535.
module source_text_tokenizer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  stt_pkg::src_item_t     src_data,
	output logic                   tok_valid,
	input  logic                   tok_ready,
	output stt_pkg::tok_item_t     tok_data
);

	logic                   push_valid, push_ready;
	stt_pkg::tok_group_t    push_data;
	logic                   head_valid, pop;
	stt_pkg::tok_group_t    head;

	stt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_data   (src_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	stt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_data   (tok_data)
	);

endmodule
